### hdl/lfmc_pkg.sv
// shared types and constants for the lagged fibonacci / multiply-with-carry generator
// no dependencies; imported by lfmc_mul64, the core and the testbench
package lfmc_pkg;

    localparam int WORD_W        = 64;
    localparam int HALF_W        = 32;
    localparam int LAG_LONG_DEF  = 17;
    localparam int LAG_SHORT_DEF = 5;
    localparam int IDX_PORT_W    = 5;

    localparam logic [HALF_W-1:0] MWC_MULT  = 32'hff676488;
    localparam logic [WORD_W-1:0] CARRY_RST = 64'h0000_0002_FFFF_FFFF;

    // result queue depth, power of two
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_GEN   = 2'd0,
        KIND_LAG   = 2'd1,
        KIND_CARRY = 2'd2
    } kind_t;

    // what a pipeline slot writes back into the ring
    typedef enum logic [1:0] {
        WR_NONE,
        WR_PROD,
        WR_LAG
    } wr_op_t;

endpackage

### hdl/lfmc_mul64.sv
// 64x64 multiplier keeping the low 64 bits, built from three registered 32x32 partials
// depends on lfmc_pkg
module lfmc_mul64 (
    input  logic                        clk,
    input  logic [lfmc_pkg::WORD_W-1:0] a,
    input  logic [lfmc_pkg::WORD_W-1:0] b,
    output logic [lfmc_pkg::WORD_W-1:0] prod
);
    import lfmc_pkg::*;

    logic [WORD_W-1:0] pll_reg;
    logic [HALF_W-1:0] plh_reg;
    logic [HALF_W-1:0] phl_reg;
    logic [HALF_W-1:0] hi_sum;

    // cross terms only matter in their low half
    always_ff @(posedge clk)
    begin
        pll_reg <= WORD_W'(a[HALF_W-1:0]) * WORD_W'(b[HALF_W-1:0]);
        plh_reg <= a[HALF_W-1:0] * b[WORD_W-1:HALF_W];
        phl_reg <= a[WORD_W-1:HALF_W] * b[HALF_W-1:0];
    end

    assign hi_sum = pll_reg[WORD_W-1:HALF_W] + plh_reg + phl_reg;
    assign prod   = {hi_sum, pll_reg[HALF_W-1:0]};

endmodule

### hdl/lagged_fib_mwc_combo_prng_core.sv
// top level of the combined lagged fibonacci / multiply-with-carry random generator
// depends on lfmc_pkg and lfmc_mul64
//
// Takes one command word per clock cycle and returns a 64-bit random word for every
// generate command. A generate multiplies the ring entries at the long and short
// pointers (mod 2^64), writes the product back at the long pointer, steps both pointers
// down with wrap, steps the multiply-with-carry word (low32 * 0xff676488 + high32) and
// returns product + carry word. A lag load writes (seed_value << 2) | 1 into entry
// lag_index (indexes at or above LAG_LONG are dropped); a carry load sets the carry word
// from the inverted low half of seed_value with bit 33 set and returns both pointers to
// their reset places. Loads and kind 3 return nothing. The ring lives in a synchronous
// memory with two read ports and one write port; per-entry valid bits make every entry
// read as 1 after reset, so no clearing pass is needed and the block takes commands
// from the first cycle after reset. A generate goes read -> partial products -> sum and
// write-back, and its random word reaches the output through a four-word result queue.
// Sustained rate is one command per cycle when cmd_ready stays high. One stall comes from
// the write-back loop: when the next generate would read the entry that the generate one
// slot ahead has not written yet, cmd_ready drops; with the default lags (17, 5) the
// pointers never meet that way and no such stall occurs. cmd_ready also drops while the
// result queue words plus the generates in flight fill the queue.
module lagged_fib_mwc_combo_prng_core #(
    parameter int LAG_LONG  = lfmc_pkg::LAG_LONG_DEF,
    parameter int LAG_SHORT = lfmc_pkg::LAG_SHORT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // command channel
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  logic [1:0]                      kind,
    input  logic [lfmc_pkg::IDX_PORT_W-1:0] lag_index,
    input  logic [lfmc_pkg::WORD_W-1:0]     seed_value,
    // result channel
    output logic                            rnd_valid,
    input  logic                            rnd_ready,
    output logic [lfmc_pkg::WORD_W-1:0]     random_value
);
    import lfmc_pkg::*;

    localparam int PTR_W     = $clog2(LAG_LONG);
    localparam int IDX_W     = (PTR_W + 1 > IDX_PORT_W) ? PTR_W + 1 : IDX_PORT_W;
    localparam int LONG_RST  = LAG_LONG - 1;
    localparam int SHORT_RST = (LAG_SHORT - 1) % LAG_LONG;
    localparam int FIFO_AW   = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = FIFO_AW + 1;
    localparam int CREDIT_W  = CNT_W + 1;

    // ---------------------------------------------------------------- state
    logic [PTR_W-1:0]  long_ptr_reg, long_ptr_next;
    logic [PTR_W-1:0]  short_ptr_reg, short_ptr_next;
    logic [WORD_W-1:0] carry_reg, carry_next;

    // ring memory and its valid bits (an entry never written reads as 1)
    logic [WORD_W-1:0]   ring_mem [LAG_LONG];
    logic [LAG_LONG-1:0] vbit_reg;
    logic [WORD_W-1:0]   rd_a_reg, rd_b_reg;
    logic                rdv_a_reg, rdv_b_reg;

    // slot 1: read data in hand, operands go into the multiplier
    wr_op_t            s1_op_reg, s1_op_next;
    logic [PTR_W-1:0]  s1_waddr_reg, s1_waddr_next;
    logic [PTR_W-1:0]  s1_raddr_b_reg;
    logic [WORD_W-1:0] s1_lag_data_reg;
    logic [WORD_W-1:0] s1_carry_reg;

    // slot 2: product ready, write-back and result push
    wr_op_t            s2_op_reg;
    logic [PTR_W-1:0]  s2_waddr_reg;
    logic [WORD_W-1:0] s2_lag_data_reg;
    logic [WORD_W-1:0] s2_carry_reg;

    // last write, for a read issued in the same cycle as that write
    logic              wb_valid_reg;
    logic [PTR_W-1:0]  wb_addr_reg;
    logic [WORD_W-1:0] wb_data_reg;

    // result queue
    logic [WORD_W-1:0]  fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] fifo_head_reg, fifo_tail_reg;
    logic [CNT_W-1:0]   fifo_cnt_reg, fifo_cnt_next;

    // ---------------------------------------------------------------- wires
    logic              cmd_fire;
    logic              rnd_pop;
    logic              hazard;
    logic [CREDIT_W-1:0] pending;
    logic [IDX_W-1:0]  idx_ext;
    logic              idx_ok;
    logic [PTR_W-1:0]  lag_addr;
    logic [WORD_W-1:0] mwc_prod;
    logic [WORD_W-1:0] opnd_a, opnd_b;
    logic [WORD_W-1:0] prod;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;
    logic              fifo_push;
    logic [WORD_W-1:0] push_data;

    function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == '0)
            r = PTR_W'(LAG_LONG - 1);
        else
            r = p - 1'b1;
        return r;
    endfunction

    // ---------------------------------------------------------------- accept side
    assign cmd_fire = cmd_valid && cmd_ready;
    assign rnd_pop  = rnd_valid && rnd_ready;

    // generate one slot ahead writes an entry that the next read would miss
    assign hazard = (s1_op_reg == WR_PROD)
                    && (s1_waddr_reg == long_ptr_reg || s1_waddr_reg == short_ptr_reg);

    // queue words plus generates still in the pipe
    assign pending = CREDIT_W'(fifo_cnt_reg)
                     + CREDIT_W'(s1_op_reg == WR_PROD)
                     + CREDIT_W'(s2_op_reg == WR_PROD);

    assign cmd_ready = !hazard && (pending < CREDIT_W'(FIFO_DEPTH));

    assign idx_ext  = IDX_W'(lag_index);
    assign idx_ok   = idx_ext < IDX_W'(LAG_LONG);
    assign lag_addr = idx_ext[PTR_W-1:0];

    assign mwc_prod = WORD_W'(carry_reg[HALF_W-1:0]) * WORD_W'(MWC_MULT);

    always_comb
    begin
        long_ptr_next  = long_ptr_reg;
        short_ptr_next = short_ptr_reg;
        carry_next     = carry_reg;
        s1_op_next     = WR_NONE;
        s1_waddr_next  = lag_addr;
        if (cmd_fire)
        begin
            unique case (kind_t'(kind))
                KIND_GEN:
                begin
                    s1_op_next     = WR_PROD;
                    s1_waddr_next  = long_ptr_reg;
                    long_ptr_next  = step_down(long_ptr_reg);
                    short_ptr_next = step_down(short_ptr_reg);
                    carry_next     = mwc_prod + WORD_W'(carry_reg[WORD_W-1:HALF_W]);
                end
                KIND_LAG:
                begin
                    if (idx_ok)
                        s1_op_next = WR_LAG;
                end
                KIND_CARRY:
                begin
                    carry_next     = {30'd0, 2'b10, ~seed_value[HALF_W-1:0]};
                    long_ptr_next  = PTR_W'(LONG_RST);
                    short_ptr_next = PTR_W'(SHORT_RST);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_ptr_reg  <= PTR_W'(LONG_RST);
            short_ptr_reg <= PTR_W'(SHORT_RST);
            carry_reg     <= CARRY_RST;
            s1_op_reg     <= WR_NONE;
            s2_op_reg     <= WR_NONE;
            wb_valid_reg  <= 1'b0;
        end
        else
        begin
            long_ptr_reg  <= long_ptr_next;
            short_ptr_reg <= short_ptr_next;
            carry_reg     <= carry_next;
            s1_op_reg     <= s1_op_next;
            s2_op_reg     <= s1_op_reg;
            wb_valid_reg  <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_waddr_reg    <= s1_waddr_next;
        s1_raddr_b_reg  <= short_ptr_reg;
        s1_lag_data_reg <= {seed_value[WORD_W-3:0], 2'b01};
        s1_carry_reg    <= carry_next;
        s2_waddr_reg    <= s1_waddr_reg;
        s2_lag_data_reg <= s1_lag_data_reg;
        s2_carry_reg    <= s1_carry_reg;
        wb_addr_reg     <= s2_waddr_reg;
        wb_data_reg     <= wr_data;
    end

    // ---------------------------------------------------------------- ring memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[s2_waddr_reg] <= wr_data;
        rd_a_reg  <= ring_mem[long_ptr_reg];
        rd_b_reg  <= ring_mem[short_ptr_reg];
        rdv_a_reg <= vbit_reg[long_ptr_reg];
        rdv_b_reg <= vbit_reg[short_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vbit_reg <= '0;
        else if (wr_en)
            vbit_reg[s2_waddr_reg] <= 1'b1;
    end

    // ---------------------------------------------------------------- operand forwarding
    // newest first: lag load one slot ahead, then the write that raced the read
    function automatic logic [WORD_W-1:0] pick(
        input logic [PTR_W-1:0]  addr,
        input logic [WORD_W-1:0] rd,
        input logic              rdv
    );
        logic [WORD_W-1:0] v;
        priority if (s2_op_reg == WR_LAG && s2_waddr_reg == addr)
            v = s2_lag_data_reg;
        else if (wb_valid_reg && wb_addr_reg == addr)
            v = wb_data_reg;
        else if (rdv)
            v = rd;
        else
            v = WORD_W'(1);
        return v;
    endfunction

    always_comb
    begin
        opnd_a = pick(s1_waddr_reg, rd_a_reg, rdv_a_reg);
        opnd_b = pick(s1_raddr_b_reg, rd_b_reg, rdv_b_reg);
    end

    lfmc_mul64 u_mul (
        .clk  (clk),
        .a    (opnd_a),
        .b    (opnd_b),
        .prod (prod)
    );

    // ---------------------------------------------------------------- write-back and result
    assign wr_en     = (s2_op_reg != WR_NONE);
    assign wr_data   = (s2_op_reg == WR_PROD) ? prod : s2_lag_data_reg;
    assign fifo_push = (s2_op_reg == WR_PROD);
    assign push_data = prod + s2_carry_reg;

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        priority if (fifo_push && !rnd_pop)
            fifo_cnt_next = fifo_cnt_reg + 1'b1;
        else if (!fifo_push && rnd_pop)
            fifo_cnt_next = fifo_cnt_reg - 1'b1;
        else
            fifo_cnt_next = fifo_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_head_reg <= '0;
            fifo_tail_reg <= '0;
            fifo_cnt_reg  <= '0;
        end
        else
        begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (fifo_push)
                fifo_tail_reg <= fifo_tail_reg + 1'b1;
            if (rnd_pop)
                fifo_head_reg <= fifo_head_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
            fifo_mem_reg[fifo_tail_reg] <= push_data;
    end

    assign rnd_valid    = (fifo_cnt_reg != '0);
    assign random_value = fifo_mem_reg[fifo_head_reg];

`ifndef NO_ASSERTIONS
    // result queue never takes a word it has no room for
    a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> (fifo_cnt_reg < CNT_W'(FIFO_DEPTH) || rnd_pop))
        else $error("result queue overflow");

    // the interlock keeps a generate from reading an entry whose product is still unwritten
    a_no_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_op_reg == WR_PROD && s2_op_reg == WR_PROD)
            |-> (s1_waddr_reg != s2_waddr_reg && s1_raddr_b_reg != s2_waddr_reg))
        else $error("generate read an entry with a product in flight");

    // every accepted generate reaches slot 2 and pushes its word there
    a_gen_push: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && kind == KIND_GEN) |-> ##2 fifo_push)
        else $error("generate lost in pipeline");

    // carry load puts both pointers back to their reset places
    a_carry_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && kind == KIND_CARRY)
            |=> (long_ptr_reg == PTR_W'(LONG_RST) && short_ptr_reg == PTR_W'(SHORT_RST)))
        else $error("pointers not reset by carry load");
`endif

endmodule

### dv/tb_lagged_fib_mwc_combo_prng_core.sv
// testbench for lagged_fib_mwc_combo_prng_core: directed table, then random command words
// depends on lfmc_pkg and the core RTL; a predictor tracks ring, carry word and pointers
module tb_lagged_fib_mwc_combo_prng_core;

    import lfmc_pkg::*;

    // kind 3 has no enum member in the package, the core drops it
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RING_LEN     = LAG_LONG_DEF;
    localparam int LONG_HOME    = LAG_LONG_DEF - 1;
    localparam int SHORT_HOME   = (LAG_SHORT_DEF - 1) % LAG_LONG_DEF;
    localparam int RANDOM_WORDS = 775;
    localparam int IDLE_PCT     = 28;
    localparam int SETTLE_CYC   = 12;
    localparam int CYCLE_LIMIT  = 400000;

    // one row of the directed table; has_word marks a result typed in by hand
    typedef struct packed {
        logic [1:0]            kind;
        logic [IDX_PORT_W-1:0] idx;
        logic [WORD_W-1:0]     seed;
        logic                  has_word;
        logic [WORD_W-1:0]     word;
    } stim_row_t;

    localparam int N_ROWS = 25;

    // directed rows: reset state, loads, ignored commands, carry-seed extremes
    localparam stim_row_t DIRECTED [N_ROWS] = '{
        // first word after reset: 1*1 + (0xffffffff*0xff676488 + 2)
        '{KIND_GEN,    5'd0,  64'h0,                     1'b1, 64'hff67_6487_0098_9b7b},
        // seed field ignored on generate
        '{KIND_GEN,    5'd31, 64'hffff_ffff_ffff_ffff,   1'b0, 64'h0},
        '{KIND_LAG,    5'd0,  64'h0,                     1'b0, 64'h0},
        '{KIND_LAG,    5'd16, 64'hffff_ffff_ffff_ffff,   1'b0, 64'h0},
        // lag index past the ring, dropped
        '{KIND_LAG,    5'd17, 64'h1234_5678_9abc_def0,   1'b0, 64'h0},
        '{KIND_LAG,    5'd31, 64'hdead_beef_cafe_f00d,   1'b0, 64'h0},
        '{KIND_UNUSED, 5'd5,  64'h0f0f_0f0f_0f0f_0f0f,   1'b0, 64'h0},
        // zero seed gives back the reset carry word, pointers go home
        '{KIND_CARRY,  5'd0,  64'h0,                     1'b0, 64'h0},
        '{KIND_GEN,    5'd0,  64'h0,                     1'b0, 64'h0},
        '{KIND_LAG,    5'd16, 64'h0,                     1'b0, 64'h0},
        '{KIND_LAG,    5'd4,  64'hffff_ffff_ffff_ffff,   1'b0, 64'h0},
        // all-ones seed: carry low half zero, next carry is 2
        '{KIND_CARRY,  5'd31, 64'hffff_ffff_ffff_ffff,   1'b0, 64'h0},
        // product ...fffd plus carry 2 wraps to all ones
        '{KIND_GEN,    5'd0,  64'h0,                     1'b1, 64'hffff_ffff_ffff_ffff},
        // top seed bit shifted out of the lag word
        '{KIND_LAG,    5'd1,  64'h8000_0000_0000_0000,   1'b0, 64'h0},
        '{KIND_LAG,    5'd12, 64'h5555_5555_5555_5555,   1'b0, 64'h0},
        '{KIND_LAG,    5'd8,  64'haaaa_aaaa_aaaa_aaaa,   1'b0, 64'h0},
        '{KIND_CARRY,  5'd10, 64'hffff_ffff_0000_0000,   1'b0, 64'h0},
        '{KIND_GEN,    5'd0,  64'h0,                     1'b0, 64'h0},
        '{KIND_GEN,    5'd21, 64'h0123_4567_89ab_cdef,   1'b0, 64'h0},
        '{KIND_GEN,    5'd0,  64'h0,                     1'b0, 64'h0},
        '{KIND_GEN,    5'd0,  64'h0,                     1'b0, 64'h0},
        '{KIND_GEN,    5'd0,  64'h0,                     1'b0, 64'h0},
        '{KIND_GEN,    5'd0,  64'h0,                     1'b0, 64'h0},
        '{KIND_GEN,    5'd0,  64'h0,                     1'b0, 64'h0},
        '{KIND_GEN,    5'd0,  64'h0,                     1'b0, 64'h0}
    };

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cmd_valid    = 1'b0;
    logic                  cmd_ready;
    logic [1:0]            kind         = KIND_GEN;
    logic [IDX_PORT_W-1:0] lag_index    = '0;
    logic [WORD_W-1:0]     seed_value   = '0;
    logic                  rnd_valid;
    logic                  rnd_ready    = 1'b0;
    logic [WORD_W-1:0]     random_value;

    // predictor state: ring, multiply-with-carry word, both pointers
    logic [WORD_W-1:0] lag_mirror [RING_LEN];
    logic [WORD_W-1:0] mwc_mirror;
    int                long_ptr;
    int                short_ptr;

    // random words still owed by the core, oldest first
    logic [WORD_W-1:0] pending_words [$];

    int  err_count   = 0;
    int  cycle_count = 0;
    // no idling on either side while set
    bit  steady      = 1'b0;

    lagged_fib_mwc_combo_prng_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .kind         (kind),
        .lag_index    (lag_index),
        .seed_value   (seed_value),
        .rnd_valid    (rnd_valid),
        .rnd_ready    (rnd_ready),
        .random_value (random_value)
    );

    always #5 clk = ~clk;

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words owed", cycle_count,
                     pending_words.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
        err_count++;
    endtask

    // pointer walks down, wraps from 0 to the top of the ring
    function automatic int step_down(input int p);
        return (p == 0) ? RING_LEN - 1 : p - 1;
    endfunction

    // advances the mirrored generator by one accepted command word;
    // a generate queues its random word (hand-typed one if given)
    task automatic advance_generator(input logic [1:0] k, input logic [IDX_PORT_W-1:0] idx,
                                     input logic [WORD_W-1:0] seed, input logic has_word,
                                     input logic [WORD_W-1:0] typed_word);
        logic [WORD_W-1:0] prod;
        case (k)
            KIND_LAG:
            begin
                if (idx < RING_LEN)
                    lag_mirror[idx] = {seed[WORD_W-3:0], 2'b01};
            end
            KIND_CARRY:
            begin
                // inverted low half, bit 33 set, bit 32 clear
                mwc_mirror = {30'd0, 2'b10, ~seed[HALF_W-1:0]};
                long_ptr   = LONG_HOME;
                short_ptr  = SHORT_HOME;
            end
            KIND_GEN:
            begin
                prod                 = lag_mirror[long_ptr] * lag_mirror[short_ptr];
                lag_mirror[long_ptr] = prod;
                long_ptr             = step_down(long_ptr);
                short_ptr            = step_down(short_ptr);
                mwc_mirror = WORD_W'(mwc_mirror[HALF_W-1:0]) * WORD_W'(MWC_MULT)
                           + WORD_W'(mwc_mirror[WORD_W-1:HALF_W]);
                pending_words.push_back(has_word ? typed_word : prod + mwc_mirror);
            end
            default:
            begin
                // unused kind, nothing changes
            end
        endcase
    endtask

    // offers one command word, with random idle cycles ahead of it, and waits for
    // the handshake; valid stays up when the next word follows without a gap
    task automatic send_command(input logic [1:0] k, input logic [IDX_PORT_W-1:0] idx,
                                input logic [WORD_W-1:0] seed, input logic has_word,
                                input logic [WORD_W-1:0] typed_word);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        kind       <= k;
        lag_index  <= idx;
        seed_value <= seed;
        do
            @(posedge clk);
        while (!cmd_ready);
        advance_generator(k, idx, seed, has_word, typed_word);
    endtask

    // sender holds off until every owed word has come back
    task automatic drain_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_seed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // result side: random back-pressure, compare each accepted word in order
    always @(posedge clk)
    begin
        if (rst_n && rnd_valid && rnd_ready)
        begin
            if (pending_words.size() == 0)
                report_mismatch("random word with nothing owed", '0, random_value);
            else if (random_value !== pending_words[0])
            begin
                report_mismatch("random_value", pending_words[0], random_value);
                void'(pending_words.pop_front());
            end
            else
                void'(pending_words.pop_front());
        end
        if (rst_n)
            rnd_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial
    begin
        int               words_sent;
        int               pick;
        logic [1:0]       k;
        logic [IDX_PORT_W-1:0] idx;

        // predictor starts from the reset state
        foreach (lag_mirror[i])
            lag_mirror[i] = 64'd1;
        mwc_mirror = CARRY_RST;
        long_ptr   = LONG_HOME;
        short_ptr  = SHORT_HOME;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (DIRECTED[r])
            send_command(DIRECTED[r].kind, DIRECTED[r].idx, DIRECTED[r].seed,
                         DIRECTED[r].has_word, DIRECTED[r].word);

        drain_results();

        // random part: mostly generates, lag loads spread over the ring,
        // some carry reseeds, a few dropped words that do not count
        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            // long stretch with both sides busy every cycle
            steady = (words_sent >= 300 && words_sent < 450);
            if (words_sent == RANDOM_WORDS / 2)
                drain_results();
            pick = $urandom_range(0, 99);
            idx  = IDX_PORT_W'($urandom_range(0, 31));
            if (pick < 68)
                k = KIND_GEN;
            else if (pick < 88)
            begin
                k = KIND_LAG;
                // mostly in range, sometimes past the ring
                if ($urandom_range(0, 9) != 0)
                    idx = IDX_PORT_W'($urandom_range(0, RING_LEN - 1));
            end
            else if (pick < 95)
                k = KIND_CARRY;
            else
                k = KIND_UNUSED;
            send_command(k, idx, pick_seed(), 1'b0, '0);
            if (k != KIND_UNUSED && !(k == KIND_LAG && idx >= RING_LEN))
                words_sent++;
        end
        steady = 1'b0;
        cmd_valid <= 1'b0;

        // wait out every owed word, then a few cycles for strays
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
